[sv/prl_pkg.sv]
// shared types and constants for the positional record list
`default_nettype none
package prl_pkg;

  // default list depth and widest memory address the depth range needs
  localparam int DEPTH_DEF  = 16;
  localparam int ADDR_MAX_W = 10;

  localparam int ID_W    = 27;
  localparam int SCORE_W = 10;
  localparam int POS_W   = 5;

  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(1000);

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_INSERT_AT  = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_REMOVE_AT  = 4'd5,
    CMD_REVERSE    = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_MAX        = 4'd8,
    CMD_MIN        = 4'd9,
    CMD_CLEAR      = 4'd10,
    CMD_READ_AT    = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_POS   = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_REMOVE,
    ST_REV_RA,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_FIND,
    ST_SCAN,
    ST_LIST_RD,
    ST_LIST_CHK,
    ST_READ_RD,
    ST_READ_WT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // one read and one write request to the record memory
  typedef struct packed {
    logic                  re;
    logic [ADDR_MAX_W-1:0] ra;
    logic                  we;
    logic [ADDR_MAX_W-1:0] wa;
    rec_t                  wd;
  } mem_req_t;

endpackage
`default_nettype wire

[sv/positional_record_list_core.sv]
// positional record list: top level with record memory and sequencer
//
//  beat      direction  fields
//  in_*      in         command, position, record_id, score_in
//  out_*     out        status, found_id, found_score, found_position, count, last
//
// How long an item takes is set by walks over the record memory (one read port,
// one write port, registered read data): inserts, removes and finds walk the
// list at most once, reverse swaps one pair at a time, and max/min scan once
// and then read entries again up to the last match.
// Synchronous active-low reset empties the list; the memory is not cleared.
// A held result beat does not block the next command from entering; the
// sequencer waits only when it has a new beat to place.
`default_nettype none
module positional_record_list_core #(
  parameter int DEPTH = prl_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_command,
  input  logic [prl_pkg::POS_W-1:0]     in_position,
  input  logic [prl_pkg::ID_W-1:0]      in_record_id,
  input  logic [prl_pkg::SCORE_W-1:0]   in_score_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [prl_pkg::ID_W-1:0]      out_found_id,
  output logic [prl_pkg::SCORE_W-1:0]   out_found_score,
  output logic [prl_pkg::POS_W-1:0]     out_found_position,
  output logic [prl_pkg::POS_W-1:0]     out_count,
  output logic                          out_last
);
  import prl_pkg::*;

  mem_req_t mreq;
  rec_t     rdata;

  // record memory
  prl_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // command sequencer
  prl_seq #(.DEPTH(DEPTH)) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_record_id       (in_record_id),
    .in_score_in        (in_score_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_id       (out_found_id),
    .out_found_score    (out_found_score),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_last           (out_last),
    .mreq               (mreq),
    .rdata              (rdata)
  );

endmodule
`default_nettype wire

[sv/prl_mem.sv]
// record memory: one write port, one read port with registered data
`default_nettype none
module prl_mem #(
  parameter int DEPTH = prl_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  prl_pkg::mem_req_t req,
  output prl_pkg::rec_t     rdata
);
  import prl_pkg::*;

  localparam int AW = $clog2(DEPTH);

  rec_t store_r [DEPTH];
  rec_t rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      store_r[req.wa[AW-1:0]] <= req.wd;
    end
    if (req.re) begin
      rdata_r <= store_r[req.ra[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/prl_seq.sv]
// command sequencer: walks the record memory and drives the result register
`default_nettype none
module prl_seq #(
  parameter int DEPTH = prl_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_command,
  input  logic [prl_pkg::POS_W-1:0]     in_position,
  input  logic [prl_pkg::ID_W-1:0]      in_record_id,
  input  logic [prl_pkg::SCORE_W-1:0]   in_score_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [prl_pkg::ID_W-1:0]      out_found_id,
  output logic [prl_pkg::SCORE_W-1:0]   out_found_score,
  output logic [prl_pkg::POS_W-1:0]     out_found_position,
  output logic [prl_pkg::POS_W-1:0]     out_count,
  output logic                          out_last,
  output prl_pkg::mem_req_t             mreq,
  input  prl_pkg::rec_t                 rdata
);
  import prl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            rv_r, rv_nxt;
  logic            out_valid_r, out_valid_nxt;

  // working registers
  cmd_t            cmd_r, cmd_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]   tag_r, tag_nxt;
  rec_t            rec_r, rec_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [CW-1:0]   nmatch_r, nmatch_nxt;
  logic [CW-1:0]   sent_r, sent_nxt;
  status_t         res_st_r, res_st_nxt;
  rec_t            res_rec_r, res_rec_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;

  // result register
  status_t          o_st_r, o_st_nxt;
  rec_t             o_rec_r, o_rec_nxt;
  logic [POS_W-1:0] o_pos_r, o_pos_nxt;
  logic [POS_W-1:0] o_cnt_r, o_cnt_nxt;
  logic             o_last_r, o_last_nxt;

  logic [XW-1:0]      pos_x, cnt_x, ipos, rpos;
  logic [SCORE_W-1:0] sat_score;
  logic [CW-1:0]      rev_j;
  logic               out_free;
  logic               better;

  assign pos_x     = XW'(in_position);
  assign cnt_x     = XW'(cnt_r);
  assign sat_score = (in_score_in > SCORE_MAX) ? SCORE_MAX : in_score_in;
  assign rev_j     = cnt_r - CW'(1) - ptr_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign better    = (cmd_r == CMD_MAX) ? (rdata.score > best_r) : (rdata.score < best_r);

  assign in_stall = (state_r != ST_IDLE);

  // insert and remove positions by command
  always_comb begin
    ipos = pos_x;
    rpos = pos_x;
    case (cmd_t'(in_command))
      CMD_PUSH_FRONT: ipos = XW'(1);
      CMD_PUSH_BACK:  ipos = cnt_x + XW'(1);
      CMD_POP_FRONT:  rpos = XW'(1);
      CMD_POP_BACK:   rpos = cnt_x;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    ptr_r     <= ptr_nxt;
    tag_r     <= tag_nxt;
    rec_r     <= rec_nxt;
    best_r    <= best_nxt;
    nmatch_r  <= nmatch_nxt;
    sent_r    <= sent_nxt;
    res_st_r  <= res_st_nxt;
    res_rec_r <= res_rec_nxt;
    res_pos_r <= res_pos_nxt;
    o_st_r    <= o_st_nxt;
    o_rec_r   <= o_rec_nxt;
    o_pos_r   <= o_pos_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_last_r  <= o_last_nxt;
  end

  // next state, memory requests and result beats
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    rec_nxt       = rec_r;
    best_nxt      = best_r;
    nmatch_nxt    = nmatch_r;
    sent_nxt      = sent_r;
    res_st_nxt    = res_st_r;
    res_rec_nxt   = res_rec_r;
    res_pos_nxt   = res_pos_r;
    o_st_nxt      = o_st_r;
    o_rec_nxt     = o_rec_r;
    o_pos_nxt     = o_pos_r;
    o_cnt_nxt     = o_cnt_r;
    o_last_nxt    = o_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    mreq          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cmd_t'(in_command);
          rec_nxt     = '{id: in_record_id, score: sat_score};
          res_st_nxt  = STS_OK;
          res_rec_nxt = '0;
          res_pos_nxt = '0;
          ptr_nxt     = '0;
          state_nxt   = ST_EMIT;
          case (cmd_t'(in_command))
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (ipos == '0 || ipos > cnt_x + XW'(1)) begin
                res_st_nxt = STS_BAD_POS;
              end else if (cnt_r == CW'(DEPTH)) begin
                res_st_nxt = STS_FULL;
              end else begin
                idx_nxt     = AW'(ipos - XW'(1));
                res_pos_nxt = ipos[POS_W-1:0];
                ptr_nxt     = cnt_r;
                state_nxt   = ST_SHIFT;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT, CMD_READ_AT: begin
              if (rpos == '0 || rpos > cnt_x) begin
                res_st_nxt = STS_BAD_POS;
              end else begin
                idx_nxt     = AW'(rpos - XW'(1));
                res_pos_nxt = rpos[POS_W-1:0];
                ptr_nxt     = CW'(rpos - XW'(1));
                state_nxt   = (cmd_t'(in_command) == CMD_READ_AT) ? ST_READ_RD : ST_REMOVE;
              end
            end
            CMD_REVERSE: begin
              if (cnt_r == '0) res_st_nxt = STS_BAD_POS;
              else state_nxt = ST_REV_RA;
            end
            CMD_FIND: begin
              state_nxt = ST_FIND;
            end
            CMD_MAX, CMD_MIN: begin
              if (cnt_r == '0) res_st_nxt = STS_BAD_POS;
              else state_nxt = ST_SCAN;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              res_st_nxt = STS_BAD_POS;
            end
          endcase
        end
      end

      // move entries idx..count-1 back by one, reading from the tail down
      ST_SHIFT: begin
        if (ptr_r > CW'(idx_r)) begin
          mreq.re = 1'b1;
          mreq.ra = ADDR_MAX_W'(ptr_r - CW'(1));
          ptr_nxt = ptr_r - CW'(1);
        end
        if (rv_r) begin
          mreq.we = 1'b1;
          mreq.wa = ADDR_MAX_W'(tag_r) + ADDR_MAX_W'(1);
          mreq.wd = rdata;
        end else if (ptr_r == CW'(idx_r)) begin
          mreq.we     = 1'b1;
          mreq.wa     = ADDR_MAX_W'(idx_r);
          mreq.wd     = rec_r;
          res_rec_nxt = rec_r;
          cnt_nxt     = cnt_r + CW'(1);
          state_nxt   = ST_EMIT;
        end
      end

      // capture the removed entry, then pull later entries forward
      ST_REMOVE: begin
        if (ptr_r < cnt_r) begin
          mreq.re = 1'b1;
          mreq.ra = ADDR_MAX_W'(ptr_r);
          ptr_nxt = ptr_r + CW'(1);
        end
        if (rv_r) begin
          if (tag_r == idx_r) begin
            res_rec_nxt = rdata;
          end else begin
            mreq.we = 1'b1;
            mreq.wa = ADDR_MAX_W'(tag_r) - ADDR_MAX_W'(1);
            mreq.wd = rdata;
          end
        end else if (ptr_r == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_EMIT;
        end
      end

      // reverse: swap entry i with entry count-1-i, one pair at a time
      ST_REV_RA: begin
        if (ptr_r >= (cnt_r >> 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          mreq.re   = 1'b1;
          mreq.ra   = ADDR_MAX_W'(ptr_r);
          state_nxt = ST_REV_RB;
        end
      end
      ST_REV_RB: begin
        // entry i is on the read data now; hold it for the second write
        rec_nxt   = rdata;
        mreq.re   = 1'b1;
        mreq.ra   = ADDR_MAX_W'(rev_j);
        state_nxt = ST_REV_WA;
      end
      ST_REV_WA: begin
        state_nxt = ST_REV_WB;
      end
      ST_REV_WB: begin
        mreq.we   = 1'b1;
        mreq.wa   = ADDR_MAX_W'(ptr_r);
        mreq.wd   = rdata;
        state_nxt = ST_REV_RA;
        ptr_nxt   = ptr_r + CW'(1);
        best_nxt  = best_r;
      end

      // find: first entry whose id matches
      ST_FIND: begin
        if (ptr_r < cnt_r) begin
          mreq.re = 1'b1;
          mreq.ra = ADDR_MAX_W'(ptr_r);
          ptr_nxt = ptr_r + CW'(1);
        end
        if (rv_r && rdata.id == rec_r.id) begin
          res_rec_nxt = rdata;
          res_pos_nxt = POS_W'(XW'(tag_r) + XW'(1));
          state_nxt   = ST_EMIT;
        end else if (!rv_r && ptr_r == cnt_r) begin
          res_st_nxt = STS_NOT_FOUND;
          state_nxt  = ST_EMIT;
        end
      end

      // first pass: extreme score and how many entries hold it
      ST_SCAN: begin
        if (ptr_r < cnt_r) begin
          mreq.re = 1'b1;
          mreq.ra = ADDR_MAX_W'(ptr_r);
          ptr_nxt = ptr_r + CW'(1);
        end
        if (rv_r) begin
          if (tag_r == '0 || better) begin
            best_nxt   = rdata.score;
            nmatch_nxt = CW'(1);
          end else if (rdata.score == best_r) begin
            nmatch_nxt = nmatch_r + CW'(1);
          end
        end else if (ptr_r == cnt_r) begin
          ptr_nxt   = '0;
          sent_nxt  = '0;
          state_nxt = ST_LIST_RD;
        end
      end

      // second pass: one beat per matching entry
      ST_LIST_RD: begin
        mreq.re   = 1'b1;
        mreq.ra   = ADDR_MAX_W'(ptr_r);
        state_nxt = ST_LIST_CHK;
      end
      ST_LIST_CHK: begin
        if (rdata.score != best_r) begin
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = ST_LIST_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          o_st_nxt      = STS_OK;
          o_rec_nxt     = rdata;
          o_pos_nxt     = POS_W'(XW'(ptr_r) + XW'(1));
          o_cnt_nxt     = POS_W'(cnt_r);
          o_last_nxt    = (sent_r + CW'(1) == nmatch_r);
          sent_nxt      = sent_r + CW'(1);
          ptr_nxt       = ptr_r + CW'(1);
          state_nxt     = (sent_r + CW'(1) == nmatch_r) ? ST_IDLE : ST_LIST_RD;
        end
      end

      // read at a position
      ST_READ_RD: begin
        mreq.re   = 1'b1;
        mreq.ra   = ADDR_MAX_W'(idx_r);
        state_nxt = ST_READ_WT;
      end
      ST_READ_WT: begin
        res_rec_nxt = rdata;
        state_nxt   = ST_EMIT;
      end

      // single result beat
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_st_nxt      = res_st_r;
          o_rec_nxt     = res_rec_r;
          o_pos_nxt     = res_pos_r;
          o_cnt_nxt     = POS_W'(cnt_r);
          o_last_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // the first half of a swap is written back here, the second half below
    if (state_r == ST_REV_WA) begin
      mreq.we = 1'b1;
      mreq.wa = ADDR_MAX_W'(ptr_r);
      mreq.wd = rdata;
    end
    if (state_r == ST_REV_WB) begin
      mreq.wa = ADDR_MAX_W'(rev_j);
      mreq.wd = rec_r;
    end

    rv_nxt  = mreq.re;
    tag_nxt = mreq.ra[AW-1:0];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_st_r;
  assign out_found_id       = o_rec_r.id;
  assign out_found_score    = o_rec_r.score;
  assign out_found_position = o_pos_r;
  assign out_count          = o_cnt_r;
  assign out_last           = o_last_r;

endmodule
`default_nettype wire

[sv/prl_checker.sv]
// port checker for the positional record list, bound to the top level
`default_nettype none
module prl_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [1:0]                    out_status,
  input wire logic [prl_pkg::ID_W-1:0]      out_found_id,
  input wire logic [prl_pkg::POS_W-1:0]     out_found_position,
  input wire logic                          out_last
);
  import prl_pkg::*;

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // an error result ends its command
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_last)
    else $error("error result not final");

  // an error result reports no record
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_found_id == '0 && out_found_position == '0)
    else $error("error result carries a record");

  // only ok beats of a max or min list may be followed by more beats
  a_more_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == STS_OK && out_found_position != '0)
    else $error("non-final beat without a record");

endmodule

bind positional_record_list_core prl_checker u_prl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_found_id       (out_found_id),
  .out_found_position (out_found_position),
  .out_last           (out_last)
);
`default_nettype wire

[sim/positional_record_list_core_tb.sv]
// self-checking testbench for the positional record list core
`timescale 1ns / 100ps
module positional_record_list_core_tb;
  import prl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  // result beat as predicted
  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   count;
    logic               last;
  } list_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [3:0]          in_command;
  logic [POS_W-1:0]    in_position;
  logic [ID_W-1:0]     in_record_id;
  logic [SCORE_W-1:0]  in_score_in;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_found_id;
  logic [SCORE_W-1:0]  out_found_score;
  logic [POS_W-1:0]    out_found_position;
  logic [POS_W-1:0]    out_count;
  logic                out_last;

  // predictor state: shadow list
  logic [ID_W-1:0]    shadow_id [LIST_DEPTH];
  logic [SCORE_W-1:0] shadow_score [LIST_DEPTH];
  int                 shadow_count;

  list_result_t pending_results[$];
  int  mismatch_count;
  int  result_count;
  int  item_count;
  int  cycle_count;
  bit  stall_enable;
  bit  gap_enable;

  positional_record_list_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_position(in_position),
    .in_record_id(in_record_id), .in_score_in(in_score_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found_id(out_found_id),
    .out_found_score(out_found_score), .out_found_position(out_found_position),
    .out_count(out_count), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int random_gap();
    if (!gap_enable) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic list_result_t make_result(logic [1:0] st, logic [ID_W-1:0] id,
                                               logic [SCORE_W-1:0] sc, int pos, logic fin);
    list_result_t r;
    r.status   = st;
    r.id       = id;
    r.score    = sc;
    r.position = POS_W'(pos);
    r.count    = POS_W'(shadow_count);
    r.last     = fin;
    return r;
  endfunction

  // list predictor: updates shadow list and queues the expected beats
  function automatic void predict_list_command(logic [3:0] cmd, int pos,
                                               logic [ID_W-1:0] rid,
                                               logic [SCORE_W-1:0] sc_raw);
    logic [SCORE_W-1:0] sc;
    logic [ID_W-1:0]    tid;
    logic [SCORE_W-1:0] tsc;
    logic [SCORE_W-1:0] best;
    bit                 done;
    sc = (sc_raw > SCORE_MAX) ? SCORE_MAX : sc_raw;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (cmd == CMD_PUSH_FRONT) pos = 1;
        else if (cmd == CMD_PUSH_BACK) pos = shadow_count + 1;
        if (pos == 0 || pos > shadow_count + 1) begin
          pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
        end else if (shadow_count >= LIST_DEPTH) begin
          pending_results.push_back(make_result(STS_FULL, 0, 0, 0, 1'b1));
        end else begin
          for (int i = shadow_count; i > pos - 1; i--) begin
            shadow_id[i]    = shadow_id[i-1];
            shadow_score[i] = shadow_score[i-1];
          end
          shadow_id[pos-1]    = rid;
          shadow_score[pos-1] = sc;
          shadow_count++;
          pending_results.push_back(make_result(STS_OK, rid, sc, pos, 1'b1));
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
        if (cmd == CMD_POP_FRONT) pos = 1;
        else if (cmd == CMD_POP_BACK) pos = shadow_count;
        if (pos == 0 || pos > shadow_count) begin
          pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
        end else begin
          tid = shadow_id[pos-1];
          tsc = shadow_score[pos-1];
          for (int i = pos - 1; i + 1 < shadow_count; i++) begin
            shadow_id[i]    = shadow_id[i+1];
            shadow_score[i] = shadow_score[i+1];
          end
          shadow_count--;
          pending_results.push_back(make_result(STS_OK, tid, tsc, pos, 1'b1));
        end
      end
      CMD_REVERSE: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count / 2; i++) begin
            tid = shadow_id[i];
            tsc = shadow_score[i];
            shadow_id[i]    = shadow_id[shadow_count-1-i];
            shadow_score[i] = shadow_score[shadow_count-1-i];
            shadow_id[shadow_count-1-i]    = tid;
            shadow_score[shadow_count-1-i] = tsc;
          end
          pending_results.push_back(make_result(STS_OK, 0, 0, 0, 1'b1));
        end
      end
      CMD_FIND: begin
        done = 1'b0;
        for (int i = 0; i < shadow_count && !done; i++) begin
          if (shadow_id[i] == rid) begin
            pending_results.push_back(make_result(STS_OK, shadow_id[i], shadow_score[i],
                                                  i + 1, 1'b1));
            done = 1'b1;
          end
        end
        if (!done)
          pending_results.push_back(make_result(STS_NOT_FOUND, 0, 0, 0, 1'b1));
      end
      CMD_MAX, CMD_MIN: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
        end else begin
          best = shadow_score[0];
          for (int i = 1; i < shadow_count; i++) begin
            if (cmd == CMD_MAX ? shadow_score[i] > best : shadow_score[i] < best)
              best = shadow_score[i];
          end
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_score[i] == best) begin
              pending_results.push_back(make_result(STS_OK, shadow_id[i], shadow_score[i],
                                                    i + 1, 1'b0));
            end
          end
          pending_results[pending_results.size()-1].last = 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        pending_results.push_back(make_result(STS_OK, 0, 0, 0, 1'b1));
      end
      CMD_READ_AT: begin
        if (pos == 0 || pos > shadow_count)
          pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
        else
          pending_results.push_back(make_result(STS_OK, shadow_id[pos-1],
                                                shadow_score[pos-1], pos, 1'b1));
      end
      default: begin
        pending_results.push_back(make_result(STS_BAD_POS, 0, 0, 0, 1'b1));
      end
    endcase
  endfunction

  // send one command beat and wait for its acceptance
  task automatic send_command(logic [3:0] cmd, logic [POS_W-1:0] pos,
                              logic [ID_W-1:0] rid, logic [SCORE_W-1:0] sc);
    int gap;
    gap = random_gap();
    // valid was dropped at the last acceptance edge; move on to a later edge
    repeat (gap + 1) @(posedge clk);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_position  <= pos;
    in_record_id <= rid;
    in_score_in  <= sc;
    do @(posedge clk); while (in_stall);
    predict_list_command(cmd, pos, rid, sc);
    item_count++;
    in_valid <= 1'b0;
  endtask

  // random stall on the result side
  always @(posedge clk) begin
    if (!rst_n || !stall_enable)
      out_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0)
      out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0)
      out_stall <= 1'b1;
    else
      out_stall <= ($urandom_range(0, 3) == 0);
  end

  // result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d id %0d", out_status, out_found_id);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_found_id !== want.id ||
            out_found_score !== want.score || out_found_position !== want.position ||
            out_count !== want.count || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp st %0d id %0d sc %0d pos %0d cnt %0d last %0d,",
                      " got st %0d id %0d sc %0d pos %0d cnt %0d last %0d"},
                     want.status, want.id, want.score, want.position, want.count,
                     want.last, out_status, out_found_id, out_found_score,
                     out_found_position, out_count, out_last);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(0, 3))
      0: return ID_W'($urandom_range(0, 7));
      1: return {ID_W{1'b1}};
      default: return ID_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] random_score();
    case ($urandom_range(0, 5))
      0: return SCORE_W'($urandom_range(1001, 1023));
      1: return SCORE_W'($urandom_range(0, 3) * 250);
      default: return SCORE_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // directed: edges, every command, error paths
  task automatic test_directed();
    send_command(CMD_POP_FRONT, 0, 0, 0);
    send_command(CMD_POP_BACK, 0, 0, 0);
    send_command(CMD_REVERSE, 0, 0, 0);
    send_command(CMD_MAX, 0, 0, 0);
    send_command(CMD_MIN, 0, 0, 0);
    send_command(CMD_FIND, 0, 5, 0);
    send_command(CMD_READ_AT, 1, 0, 0);
    send_command(CMD_PUSH_BACK, 0, {ID_W{1'b1}}, 10'd1023);
    send_command(CMD_PUSH_FRONT, 31, 0, 0);
    send_command(CMD_INSERT_AT, 0, 3, 5);
    send_command(CMD_INSERT_AT, 4, 3, 5);
    send_command(CMD_INSERT_AT, 2, 3, 1000);
    send_command(CMD_MAX, 0, 0, 0);
    send_command(CMD_MIN, 0, 0, 0);
    send_command(CMD_REVERSE, 0, 0, 0);
    send_command(CMD_FIND, 0, 3, 0);
    send_command(CMD_READ_AT, 3, 0, 0);
    send_command(CMD_READ_AT, 4, 0, 0);
    send_command(CMD_REMOVE_AT, 0, 0, 0);
    send_command(CMD_REMOVE_AT, 2, 0, 0);
    send_command(4'd12, 1, 1, 1);
    send_command(4'd15, 16, 0, 0);
    send_command(CMD_CLEAR, 0, 0, 0);
  endtask

  // fill to depth, overflow, then scan a full list
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++)
      send_command(CMD_PUSH_BACK, 0, ID_W'(i + 1), SCORE_W'((i % 3) * 500));
    send_command(CMD_PUSH_FRONT, 0, 7, 7);
    send_command(CMD_INSERT_AT, 17, 7, 7);
    send_command(CMD_INSERT_AT, 18, 7, 7);
    send_command(CMD_READ_AT, 16, 0, 0);
    send_command(CMD_READ_AT, 17, 0, 0);
    send_command(CMD_MAX, 0, 0, 0);
    send_command(CMD_MIN, 0, 0, 0);
    send_command(CMD_REVERSE, 0, 0, 0);
    send_command(CMD_REMOVE_AT, 16, 0, 0);
    wait_drained();
  endtask

  // random mix biased toward valid positions
  task automatic test_random(int n);
    logic [3:0]       cmd;
    logic [POS_W-1:0] pos;
    int               r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) cmd = ($urandom_range(0, 1) != 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (r < 40) cmd = CMD_INSERT_AT;
      else if (r < 97) cmd = 4'($urandom_range(3, 11));
      else cmd = 4'($urandom_range(0, 15));
      if (cmd == CMD_CLEAR && $urandom_range(0, 2) != 0) cmd = CMD_READ_AT;
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom);
      else pos = POS_W'($urandom_range(1, shadow_count + 1));
      if (cmd == CMD_FIND && shadow_count > 0 && $urandom_range(0, 1) != 0)
        send_command(cmd, pos, shadow_id[$urandom_range(0, shadow_count - 1)], 0);
      else
        send_command(cmd, pos, random_id(), random_score());
      if (k == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = '0;
    in_position    = '0;
    in_record_id   = '0;
    in_score_in    = '0;
    stall_enable   = 1'b0;
    gap_enable     = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    item_count     = 0;
    shadow_count   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_enable = 1'b1;
    gap_enable   = 1'b1;
    test_full_list();
    test_random(200);
    stall_enable = 1'b0;
    gap_enable   = 1'b0;
    test_random(60);
    stall_enable = 1'b1;
    gap_enable   = 1'b1;
    test_random(160);
    wait_drained();
    repeat (60) @(posedge clk);
    $display("covered %0d commands and %0d result beats, including full, empty and bad",
             item_count, result_count);
    $display("position cases, out-of-range scores and multi-beat max/min scans");
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
sv/prl_pkg.sv
sv/prl_mem.sv
sv/prl_seq.sv
sv/positional_record_list_core.sv
sv/prl_checker.sv
sim/positional_record_list_core_tb.sv
